// ===== design/aes_pkg.sv =====
`timescale 1ns / 1ps
package aes_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;
    localparam int WORD_W  = 32;
    localparam int NUM_RK  = 44;
    localparam int RK_AW   = 6;
    localparam int NUM_RND = 10;
    localparam int RND_W   = 4;

    // Configuration register indexes.
    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    typedef enum logic [1:0] {
        ST_EXPAND,
        ST_IDLE,
        ST_LOAD,
        ST_ROUND
    } aes_state_t;

    // Control passed from the sequencer to the column lanes.
    typedef struct packed {
        logic enc;
        logic first;
        logic last;
    } lane_ctrl_t;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [NUM_RND] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Substitute each byte of a word.
    function automatic logic [31:0] sub_word(input logic [31:0] w);
        logic [31:0] r;
        for (int j = 0; j < 4; j++)
        begin
            r[8*j +: 8] = FWD_SBOX[w[8*j +: 8]];
        end
        return r;
    endfunction

endpackage

// ===== design/aes_ram.sv =====
`timescale 1ns / 1ps
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/aes_key_exp.sv =====
`timescale 1ns / 1ps
module aes_key_exp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [aes_pkg::BLOCK_W-1:0]   key,
    output logic                          wr_en,
    output logic [aes_pkg::RK_AW-1:0]     wr_addr,
    output logic [aes_pkg::WORD_W-1:0]    wr_data,
    output logic                          done
);
    import aes_pkg::*;

    logic [127:0]     win_reg, win_next;
    logic [RK_AW-1:0] idx_reg, idx_next;
    logic [RND_W-1:0] rc_reg, rc_next;
    logic             run_reg, run_next;
    logic [31:0]      w_new;
    logic [31:0]      prev;

    // Next schedule word from the sliding window of the last four words.
    always_comb
    begin
        prev = win_reg[127:96];
        if (idx_reg[1:0] == 2'd0)
        begin
            w_new = win_reg[31:0] ^ sub_word({prev[7:0], prev[31:8]})
                  ^ {24'd0, RCON[rc_reg]};
        end
        else
        begin
            w_new = win_reg[31:0] ^ prev;
        end
    end

    // Sweep through all 44 words, one per cycle.
    always_comb
    begin
        win_next = win_reg;
        idx_next = idx_reg;
        rc_next  = rc_reg;
        run_next = run_reg;
        wr_en    = 1'b0;
        wr_addr  = idx_reg;
        wr_data  = w_new;
        if (go)
        begin
            win_next = key;
            idx_next = '0;
            rc_next  = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            wr_en = 1'b1;
            if (idx_reg < RK_AW'(4))
            begin
                wr_data = win_reg[32*idx_reg[1:0] +: 32];
            end
            else
            begin
                win_next = {w_new, win_reg[127:32]};
                if (idx_reg[1:0] == 2'd3)
                begin
                    rc_next = rc_reg + RND_W'(1);
                end
            end
            if (idx_reg == RK_AW'(NUM_RK - 1))
            begin
                run_next = 1'b0;
            end
            idx_next = idx_reg + RK_AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            idx_reg <= '0;
            rc_reg  <= '0;
        end
        else
        begin
            run_reg <= run_next;
            idx_reg <= idx_next;
            rc_reg  <= rc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    assign done = !run_reg && !go;

endmodule

// ===== design/aes_lane.sv =====
`timescale 1ns / 1ps
module aes_lane (
    input  aes_pkg::lane_ctrl_t ctrl,
    input  logic [31:0]         col_in,
    input  logic [31:0]         rk,
    output logic [31:0]         col_out
);
    import aes_pkg::*;

    logic [7:0] b [4];
    logic [7:0] m [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [31:0] sub;
    logic [31:0] mixed;

    // One column after shift: substitute, mix, add key (decrypt: sub,
    // add key, inverse mix); round 0 adds key only, last skips mix.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            sub[8*r +: 8] = ctrl.enc ? FWD_SBOX[col_in[8*r +: 8]]
                                     : INV_SBOX[col_in[8*r +: 8]];
        end
        for (int r = 0; r < 4; r++)
        begin
            b[r] = ctrl.enc ? sub[8*r +: 8] : sub[8*r +: 8] ^ rk[8*r +: 8];
            x2[r] = xtime(b[r]);
            x4[r] = xtime(x2[r]);
            x8[r] = xtime(x4[r]);
        end
        for (int r = 0; r < 4; r++)
        begin
            if (ctrl.enc)
            begin
                m[r] = x2[r] ^ (x2[(r+1)%4] ^ b[(r+1)%4]) ^ b[(r+2)%4] ^ b[(r+3)%4];
            end
            else
            begin
                m[r] = (x8[r] ^ x4[r] ^ x2[r])
                     ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ b[(r+1)%4])
                     ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ b[(r+2)%4])
                     ^ (x8[(r+3)%4] ^ b[(r+3)%4]);
            end
            mixed[8*r +: 8] = m[r];
        end
        if (ctrl.first)
        begin
            col_out = col_in ^ rk;
        end
        else if (ctrl.last)
        begin
            col_out = sub ^ rk;
        end
        else if (ctrl.enc)
        begin
            col_out = mixed ^ rk;
        end
        else
        begin
            col_out = mixed;
        end
    end

endmodule

// ===== design/aes128_block_cipher.sv =====
`timescale 1ns / 1ps
// AES-128 engine, encrypt or decrypt one 16-byte block per item.
// Configuration: write key_low (index 0) and key_high (index 1) through
// cfg_we/cfg_index/cfg_data. Each write starts a key expansion that fills
// the round-key RAM one word per cycle. Unless an item is in flight,
// busy stays high from the write until that expansion has finished.
// Input: an item is taken when start is high and busy is low; mode picks
// encrypt (1) or decrypt (0), block_low/block_high carry the data.
// Each of the eleven key additions first fetches its four round-key words
// one at a time through the single read port of the schedule RAM (ST_LOAD),
// then passes the state through the four column lanes (ST_ROUND); done is
// registered from the last ST_ROUND step.
// Only one item is in flight at a time. A new item can be accepted
// in the cycle in which done is high.
// Output: result_low/result_high are valid for the single cycle in which
// done is high; the receiver cannot stall.
// Reset: expands the all-zero key; busy is high until that expansion ends.
module aes128_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [63:0] block_low,
    input  logic [63:0] block_high,
    output logic        done,
    output logic [63:0] result_low,
    output logic [63:0] result_high
);
    import aes_pkg::*;

    aes_state_t state_reg, state_next;
    logic [63:0]      key_lo_reg, key_hi_reg;
    logic [127:0]     st_reg, st_next;
    logic [127:0]     shifted, merged;
    logic             enc_reg, enc_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic [1:0]       col_reg, col_next;
    logic [1:0]       ld_slot, rd_col;
    logic             done_reg, done_next;
    logic             kick_reg;
    logic             exp_wr;
    logic [RK_AW-1:0] exp_addr, rd_addr;
    logic [31:0]      exp_data;
    logic             exp_done;
    logic [127:0]     rk_reg, rk_next;
    logic [31:0]      rk_word;
    logic [RND_W-1:0] key_rnd;
    lane_ctrl_t       ctrl;
    logic [RK_AW-1:0] rd_base;

    // Key registers; any key write or reset restarts expansion.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_lo_reg <= '0;
            key_hi_reg <= '0;
            kick_reg   <= 1'b1;
        end
        else
        begin
            kick_reg <= cfg_we;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_LOW:  key_lo_reg <= cfg_data;
                    CFG_KEY_HIGH: key_hi_reg <= cfg_data;
                    default:      key_lo_reg <= key_lo_reg;
                endcase
            end
        end
    end

    aes_key_exp u_exp (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (kick_reg),
        .key     ({key_hi_reg, key_lo_reg}),
        .wr_en   (exp_wr),
        .wr_addr (exp_addr),
        .wr_data (exp_data),
        .done    (exp_done)
    );

    aes_ram #(.WIDTH(32), .DEPTH(NUM_RK)) u_rk_ram (
        .clk     (clk),
        .wr_en   (exp_wr),
        .wr_addr (exp_addr),
        .wr_data (exp_data),
        .rd_addr (rd_addr),
        .rd_data (rk_word)
    );

    // Round keys are gathered one word per cycle, four reads per round.
    // The address follows the next-state round and word, so word 0 of a
    // round is requested in the cycle before the load phase starts.
    // Round index used for key: enc counts up, dec counts down.
    assign key_rnd = enc_next ? rnd_next : RND_W'(NUM_RND) - rnd_next;
    assign rd_base = RK_AW'({key_rnd, 2'b00});
    assign rd_col  = col_next - 2'd1;
    assign rd_addr = rd_base + RK_AW'(rd_col);
    assign ld_slot = col_reg - 2'd1;

    // Shift rows (inverse shift for decrypt) on the whole state, ahead of the lanes; round 0 passes it unshifted.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (rnd_reg == '0)
                begin
                    shifted[32*c + 8*r +: 8] = st_reg[32*c + 8*r +: 8];
                end
                else if (enc_reg)
                begin
                    shifted[32*c + 8*r +: 8] = st_reg[32*((c+r)%4) + 8*r +: 8];
                end
                else
                begin
                    shifted[32*c + 8*r +: 8] = st_reg[32*((c-r+4)%4) + 8*r +: 8];
                end
            end
        end
    end

    assign ctrl.enc   = enc_reg;
    assign ctrl.first = (rnd_reg == '0);
    assign ctrl.last  = (rnd_reg == RND_W'(NUM_RND));

    // Four column lanes; the merged state is their concatenation.
    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        aes_lane u_lane (
            .ctrl    (ctrl),
            .col_in  (shifted[32*g +: 32]),
            .rk      (rk_reg[32*g +: 32]),
            .col_out (merged[32*g +: 32])
        );
    end

    // Sequencer: four key-word fetches per round, then one lane step.
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        enc_next   = enc_reg;
        rnd_next   = rnd_reg;
        col_next   = col_reg;
        rk_next    = rk_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_EXPAND:
            begin
                if (exp_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (kick_reg)
                begin
                    state_next = ST_EXPAND;
                end
                else if (start)
                begin
                    st_next    = {block_high, block_low};
                    enc_next   = mode;
                    rnd_next   = '0;
                    col_next   = 2'd1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // RAM word for col_reg-1 arrives this cycle.
                rk_next[32*ld_slot +: 32] = rk_word;
                col_next = col_reg + 2'd1;
                if (col_reg == 2'd0)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                st_next = merged;
                if (rnd_reg == RND_W'(NUM_RND))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rnd_next   = rnd_reg + RND_W'(1);
                    col_next   = 2'd1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ST_LOAD issues address for word col_reg while capturing the previous
    // one; the first word is addressed in the cycle before entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EXPAND;
            rnd_reg   <= '0;
            col_reg   <= '0;
            enc_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            col_reg   <= (state_next == ST_LOAD && state_reg != ST_LOAD) ? 2'd1 : col_next;
            enc_reg   <= enc_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        rk_reg <= rk_next;
    end

    assign busy        = (state_reg != ST_IDLE) || kick_reg || cfg_we;
    assign done        = done_reg;
    assign result_low  = st_reg[63:0];
    assign result_high = st_reg[127:64];

endmodule

// ===== design/aes_checker.sv =====
`timescale 1ns / 1ps
module aes_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_we
);

    // A result strobe lasts one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held longer than one cycle");

    // An accepted item makes the block busy next cycle.
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("not busy after accept");

    // A key write keeps the block busy in the following cycle.
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy) else $error("idle right after key write");

    // No result without work in progress in the previous cycle.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result without work");

endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cfg_we (cfg_we)
);
